FILE: design/sbpf_pkg.sv
// Package for the servo-bus packet framer: command codes, header bytes,
// byte-sequence indexes, the result type and the byte-wise CRC-16 function.
// No dependencies.
package sbpf_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;
    typedef logic [3:0]  t_idx;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PARAM = 1'b1
    } t_cmd;

    // One byte of the framed stream
    typedef struct packed {
        t_byte tx_byte;
        logic  last_of_packet;
    } t_tx;

    localparam t_byte HDR_SYNC     = 8'hFF;
    localparam t_byte HDR_MARK     = 8'hFD;
    localparam t_byte HDR_RESERVED = 8'h00;
    localparam t_word LEN_EXTRA    = 16'd3;
    localparam t_word CRC_POLY     = 16'h8005;

    // Byte positions within a start request
    localparam t_idx IDX_SYNC0    = 4'd0;
    localparam t_idx IDX_SYNC1    = 4'd1;
    localparam t_idx IDX_MARK     = 4'd2;
    localparam t_idx IDX_RESERVED = 4'd3;
    localparam t_idx IDX_ID       = 4'd4;
    localparam t_idx IDX_LEN_LO   = 4'd5;
    localparam t_idx IDX_LEN_HI   = 4'd6;
    localparam t_idx IDX_INSTR    = 4'd7;
    localparam t_idx IDX_CRC_LO   = 4'd8;
    localparam t_idx IDX_CRC_HI   = 4'd9;

    // Byte positions within a parameter request
    localparam t_idx PIDX_DATA    = 4'd0;
    localparam t_idx PIDX_CRC_LO  = 4'd1;
    localparam t_idx PIDX_CRC_HI  = 4'd2;

    // Fold one byte into the CRC, MSB first, no reflection
    function automatic t_word crc16_byte(input t_word crc, input t_byte b);
        t_word c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: design/sbpf_if.sv
// Channel interfaces of the servo-bus packet framer: request and byte stream.
// Depends on sbpf_pkg for the field types.
interface sbpf_in_if;
    logic             valid;
    logic             ready;
    logic             command;
    sbpf_pkg::t_byte  dev_id;
    sbpf_pkg::t_byte  instruction_code;
    sbpf_pkg::t_word  param_count;
    sbpf_pkg::t_byte  param_byte;

    modport source (output valid, command, dev_id, instruction_code, param_count,
                    param_byte, input ready);
    modport sink   (input valid, command, dev_id, instruction_code, param_count,
                    param_byte, output ready);
endinterface

interface sbpf_out_if;
    logic             valid;
    logic             ready;
    sbpf_pkg::t_byte  tx_byte;
    logic             last_of_packet;

    modport source (output valid, tx_byte, last_of_packet, input ready);
    modport sink   (input valid, tx_byte, last_of_packet, output ready);
endinterface

FILE: design/servo_bus_packet_framer_crc16.sv
// Top level of the servo-bus packet framer with CRC-16.
// Depends on sbpf_pkg, sbpf_if, sbpf_seq and sbpf_out.
//
//   channel  dir  handshake        payload
//   i_req    in   valid / ready    command, dev_id, instruction_code,
//                                  param_count, param_byte
//   o_rsp    out  valid / ready    tx_byte, last_of_packet
//
// One byte leaves per cycle unless the output stalls. A start request
// appends the CRC only with a zero count, a parameter request only when it
// closes the packet; a dropped parameter emits no byte. The byte-wise CRC
// update sits between the request register and the output register. Reset
// is synchronous, active low, and clears the CRC, the remaining count and
// the open flag. A stalled output holds its byte and stops the sequencer.
module servo_bus_packet_framer_crc16 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbpf_in_if.sink    i_req,
    sbpf_out_if.source o_rsp
);
    import sbpf_pkg::*;

    logic tx_valid;
    logic tx_ready;
    t_tx  tx;

    sbpf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_tx_valid (tx_valid),
        .o_tx       (tx),
        .i_tx_ready (tx_ready)
    );

    sbpf_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tx_valid (tx_valid),
        .i_tx       (tx),
        .o_tx_ready (tx_ready),
        .o_rsp      (o_rsp)
    );

endmodule

FILE: design/sbpf_seq.sv
// Request register and byte sequencer: walks the bytes of one held request,
// keeps the running CRC, the open-packet flag and the remaining count.
// Depends on sbpf_pkg and sbpf_in_if.
module sbpf_seq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sbpf_in_if.sink      i_req,
    output logic         o_tx_valid,
    output sbpf_pkg::t_tx o_tx,
    input  logic         i_tx_ready
);
    import sbpf_pkg::*;

    // Held request (payload, no reset)
    t_cmd  r_cmd,  n_cmd;
    t_byte r_id,   n_id;
    t_byte r_ins,  n_ins;
    t_word r_cnt,  n_cnt;
    t_byte r_pb,   n_pb;
    // Control state
    logic  r_busy, n_busy;
    t_idx  r_idx,  n_idx;
    t_word r_crc,  n_crc;
    t_word r_remain, n_remain;
    logic  r_open, n_open;

    logic  emit, feed, last, done, step, accept;
    t_byte cur_byte;
    t_word len, crc_base, crc_next;

    assign len      = r_cnt + LEN_EXTRA;
    assign crc_base = (r_cmd == CMD_START && r_idx == IDX_SYNC0) ? '0 : r_crc;
    assign crc_next = crc16_byte(crc_base, cur_byte);

    // Select the current byte of the held request
    always_comb begin
        emit     = 1'b0;
        feed     = 1'b0;
        last     = 1'b0;
        done     = 1'b0;
        cur_byte = '0;
        if (r_cmd == CMD_START) begin
            emit = 1'b1;
            feed = 1'b1;
            case (r_idx)
                IDX_SYNC0:    cur_byte = HDR_SYNC;
                IDX_SYNC1:    cur_byte = HDR_SYNC;
                IDX_MARK:     cur_byte = HDR_MARK;
                IDX_RESERVED: cur_byte = HDR_RESERVED;
                IDX_ID:       cur_byte = r_id;
                IDX_LEN_LO:   cur_byte = len[7:0];
                IDX_LEN_HI:   cur_byte = len[15:8];
                IDX_INSTR:    cur_byte = r_ins;
                IDX_CRC_LO: begin
                    cur_byte = r_crc[7:0];
                    feed     = 1'b0;
                end
                IDX_CRC_HI: begin
                    cur_byte = r_crc[15:8];
                    feed     = 1'b0;
                    last     = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                    feed = 1'b0;
                end
            endcase
            done = (r_cnt == '0) ? (r_idx == IDX_CRC_HI) : (r_idx == IDX_INSTR);
        end else begin
            case (r_idx)
                PIDX_DATA: begin
                    // Drop a parameter with no open packet
                    emit     = r_open;
                    feed     = r_open;
                    cur_byte = r_pb;
                    done     = !r_open || (r_remain != 16'd1);
                end
                PIDX_CRC_LO: begin
                    emit     = 1'b1;
                    cur_byte = r_crc[7:0];
                end
                PIDX_CRC_HI: begin
                    emit     = 1'b1;
                    cur_byte = r_crc[15:8];
                    last     = 1'b1;
                    done     = 1'b1;
                end
                default: done = 1'b1;
            endcase
        end
    end

    assign step        = r_busy && (!emit || i_tx_ready);
    assign i_req.ready = !r_busy || (step && done);
    assign accept      = i_req.valid && i_req.ready;

    assign o_tx_valid          = r_busy && emit;
    assign o_tx.tx_byte        = cur_byte;
    assign o_tx.last_of_packet = last;

    // Next state: load a request, advance the sequence, update CRC and counters
    always_comb begin
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_ins    = r_ins;
        n_cnt    = r_cnt;
        n_pb     = r_pb;
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_remain = r_remain;
        n_open   = r_open;
        if (step) begin
            n_idx = done ? '0 : r_idx + 4'd1;
            if (done) begin
                n_busy = 1'b0;
            end
            if (feed) begin
                n_crc = crc_next;
            end
            if (r_cmd == CMD_START && r_idx == IDX_INSTR && r_cnt != '0) begin
                n_open   = 1'b1;
                n_remain = r_cnt;
            end
            if (r_cmd == CMD_PARAM && r_idx == PIDX_DATA && r_open) begin
                n_remain = r_remain - 16'd1;
            end
            if (last) begin
                n_crc    = '0;
                n_open   = 1'b0;
                n_remain = '0;
            end
        end
        if (accept) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_cmd  = t_cmd'(i_req.command);
            n_id   = i_req.dev_id;
            n_ins  = i_req.instruction_code;
            n_cnt  = i_req.param_count;
            n_pb   = i_req.param_byte;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_id  <= n_id;
        r_ins <= n_ins;
        r_cnt <= n_cnt;
        r_pb  <= n_pb;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_crc    <= '0;
            r_remain <= '0;
            r_open   <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_remain <= n_remain;
            r_open   <= n_open;
        end
    end

endmodule

FILE: design/sbpf_out.sv
// Output register of the framer: holds one byte until the sink takes it.
// Depends on sbpf_pkg and sbpf_out_if.
module sbpf_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tx_valid,
    input  sbpf_pkg::t_tx i_tx,
    output logic          o_tx_ready,
    sbpf_out_if.source    o_rsp
);
    import sbpf_pkg::*;

    logic r_valid, n_valid;
    t_tx  r_data,  n_data;

    assign o_tx_ready = !r_valid || o_rsp.ready;

    // Load on a new byte, drop once taken
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_tx_ready) begin
            n_valid = i_tx_valid;
            n_data  = i_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.tx_byte        = r_data.tx_byte;
    assign o_rsp.last_of_packet = r_data.last_of_packet;

endmodule
